>>> rtl/first_fit_waitlist_table_top_macros.svh
// Assertion macros for the first-fit waitlist table.
`ifndef FIRST_FIT_WAITLIST_TABLE_TOP_MACROS_SVH
`define FIRST_FIT_WAITLIST_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define FFWT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define FFWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/ffwt_pkg.sv
// Package: constants, payload types, command types and key helper of the waitlist table.
`timescale 1ns / 1ps

package ffwt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int NAME_BYTES  = 20;

   localparam int KEY_BYTES = 19;
   localparam int KEY_W     = 8 * KEY_BYTES;
   localparam int SIZE_W    = 16;
   localparam int ENTRY_W   = KEY_W + SIZE_W;
   localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LIST   = 2'd2,
      OP_SHOW   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      STS_INSERTED  = 3'd0,
      STS_DUPLICATE = 3'd1,
      STS_FULL      = 3'd2,
      STS_REMOVED   = 3'd3,
      STS_NOT_FOUND = 3'd4,
      STS_ENTRY     = 3'd5,
      STS_NONE      = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_REMOVE,
      S_SHIFT,
      S_LIST
   } state_type;

   typedef enum logic [1:0] {
      SRC_KEY,
      SRC_ENTRY,
      SRC_PEND,
      SRC_NONE
   } out_src_type;

   typedef enum logic {
      WR_APPEND,
      WR_SHIFT
   } wr_sel_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] name_word_low;
      logic [63:0] name_word_mid;
      logic [23:0] name_word_high;
      logic [15:0] party_size;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] out_name_low;
      logic [63:0] out_name_mid;
      logic [23:0] out_name_high;
      logic [15:0] out_size;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        capture;
      logic        idx_clr;
      logic        idx_inc;
      logic        ram_we;
      wr_sel_type  wr_sel;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        out_load;
      out_src_type out_src;
      status_type  out_status;
      logic        out_last;
      logic        pend_load;
      logic        pend_clr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic at_end;
      logic full;
      logic name_eq;
      logic size_fit;
      logic list_all;
      logic pend_valid;
      logic out_ok;
   } dp_stat_type;

   // cut the name at its first zero byte and at NAME_BYTES-1 bytes
   function automatic logic [KEY_W-1:0] make_key(logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] k;
      logic             ended;
      k     = '0;
      ended = 1'b0;
      for (int n = 0; n < KEY_BYTES; n++) begin
         if (n >= NAME_BYTES - 1 || raw[8*n +: 8] == 8'h00) begin
            ended = 1'b1;
         end
         if (!ended) begin
            k[8*n +: 8] = raw[8*n +: 8];
         end
      end
      return k;
   endfunction

endpackage

>>> rtl/first_fit_waitlist_table_top.sv
// Top level of the first-fit waitlist table: controller, datapath and checks.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one command transaction:
//   insert, remove first fit, list all or show fitting. rsp channel
//   (rsp_valid/rsp_stall/rsp_data) returns the results; the last one of each
//   command has last set. Insert and remove give one result, list and show one
//   result per reported entry, or a single none result.
//   One command is worked on at a time; req_stall is high while it runs.
//   The table is scanned through the single read port of the entry RAM, one
//   entry per cycle except while a result waits on a stalled receiver; a
//   removal then compacts the entries behind the removed one.
//   The result register decouples the sides: a new command is taken while the
//   previous result still waits. A stalled receiver holds rsp_data and pauses
//   the scan whenever a further result is ready.
//   Reset (synchronous, active high) empties the table and drops any pending
//   result; entry storage is not cleared.
`timescale 1ns / 1ps
`include "first_fit_waitlist_table_top_macros.svh"

module first_fit_waitlist_table_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffwt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffwt_pkg::rsp_type  rsp_data
);

   ffwt_pkg::ctrl_cmd_type cmd;
   ffwt_pkg::dp_stat_type  stat;

   ffwt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (ffwt_pkg::opcode_type'(req_data.opcode)),
      .stat       (stat),
      .cmd        (cmd)
   );

   ffwt_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `FFWT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `FFWT_ASSERT_IMPLY(a_no_append_when_full, clock, reset, cmd.cnt_inc, !stat.full)
   `FFWT_ASSERT_IMPLY(a_load_only_when_free, clock, reset, cmd.out_load, stat.out_ok)

endmodule

>>> rtl/ffwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ffwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ffwt_datapath.sv
// Datapath: captured transaction, scan index, entry count, table RAM, pending and output registers.
`timescale 1ns / 1ps

module ffwt_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ffwt_pkg::req_type      req_data,
   input  ffwt_pkg::ctrl_cmd_type cmd,
   output ffwt_pkg::dp_stat_type  stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ffwt_pkg::rsp_type      rsp_data
);

   logic [ffwt_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [ffwt_pkg::SIZE_W-1:0] size_ff, size_in;
   logic                        list_all_ff, list_all_in;
   logic [ffwt_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [ffwt_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ffwt_pkg::CNT_W-1:0]  idx_prev;
   logic [ffwt_pkg::KEY_W-1:0]  pend_name_ff, pend_name_in;
   logic [ffwt_pkg::SIZE_W-1:0] pend_size_ff, pend_size_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ffwt_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                          ram_we;
   logic [ffwt_pkg::IDX_W-1:0]    wr_addr;
   logic [ffwt_pkg::ENTRY_W-1:0]  wr_data;
   logic [ffwt_pkg::IDX_W-1:0]    rd_addr;
   logic [ffwt_pkg::ENTRY_W-1:0]  rd_data;
   logic [ffwt_pkg::KEY_W-1:0]    rd_name;
   logic [ffwt_pkg::SIZE_W-1:0]   rd_size;
   logic [ffwt_pkg::KEY_W-1:0]    sel_name;
   logic [ffwt_pkg::SIZE_W-1:0]   sel_size;

   assign rd_name = rd_data[ffwt_pkg::KEY_W-1:0];
   assign rd_size = rd_data[ffwt_pkg::ENTRY_W-1:ffwt_pkg::KEY_W];

   always_comb begin
      key_in      = key_ff;
      size_in     = size_ff;
      list_all_in = list_all_ff;
      if (cmd.capture) begin
         key_in      = ffwt_pkg::make_key({req_data.name_word_high, req_data.name_word_mid,
                                           req_data.name_word_low});
         size_in     = req_data.party_size;
         list_all_in = (ffwt_pkg::opcode_type'(req_data.opcode) == ffwt_pkg::OP_LIST);
      end
   end

   always_comb begin
      priority if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + ffwt_pkg::CNT_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_comb begin
      priority if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + ffwt_pkg::CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - ffwt_pkg::CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // read address is the next index, so the registered rd_data matches idx_ff
   assign rd_addr  = idx_in[ffwt_pkg::IDX_W-1:0];
   assign idx_prev = idx_ff - ffwt_pkg::CNT_W'(1);
   assign ram_we   = cmd.ram_we;

   always_comb begin
      unique case (cmd.wr_sel)
         ffwt_pkg::WR_APPEND: begin
            wr_addr = cnt_ff[ffwt_pkg::IDX_W-1:0];
            wr_data = {size_ff, key_ff};
         end
         ffwt_pkg::WR_SHIFT: begin
            wr_addr = idx_prev[ffwt_pkg::IDX_W-1:0];
            wr_data = rd_data;
         end
         default: begin
            wr_addr = cnt_ff[ffwt_pkg::IDX_W-1:0];
            wr_data = {size_ff, key_ff};
         end
      endcase
   end

   ffwt_ram #(
      .WIDTH (ffwt_pkg::ENTRY_W),
      .DEPTH (ffwt_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      pend_name_in  = pend_name_ff;
      pend_size_in  = pend_size_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.pend_load) begin
         pend_name_in  = rd_name;
         pend_size_in  = rd_size;
         pend_valid_in = 1'b1;
      end else if (cmd.pend_clr) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      unique case (cmd.out_src)
         ffwt_pkg::SRC_KEY: begin
            sel_name = key_ff;
            sel_size = size_ff;
         end
         ffwt_pkg::SRC_ENTRY: begin
            sel_name = rd_name;
            sel_size = rd_size;
         end
         ffwt_pkg::SRC_PEND: begin
            sel_name = pend_name_ff;
            sel_size = pend_size_ff;
         end
         default: begin
            sel_name = '0;
            sel_size = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = cmd.out_status;
         rsp_data_in.out_name_low  = sel_name[63:0];
         rsp_data_in.out_name_mid  = sel_name[127:64];
         rsp_data_in.out_name_high = sel_name[151:128];
         rsp_data_in.out_size      = sel_size;
         rsp_data_in.last          = cmd.out_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      size_ff      <= size_in;
      list_all_ff  <= list_all_in;
      idx_ff       <= idx_in;
      pend_name_ff <= pend_name_in;
      pend_size_ff <= pend_size_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign stat.at_end     = (idx_ff == cnt_ff);
   assign stat.full       = (cnt_ff == ffwt_pkg::CNT_W'(ffwt_pkg::TABLE_DEPTH));
   assign stat.name_eq    = (rd_name == key_ff);
   assign stat.size_fit   = (rd_size <= size_ff);
   assign stat.list_all   = list_all_ff;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_ok     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/ffwt_ctrl.sv
// Controller: state machine that sequences insert, remove, compaction and list scans.
`timescale 1ns / 1ps

module ffwt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ffwt_pkg::opcode_type    req_opcode,
   input  ffwt_pkg::dp_stat_type   stat,
   output ffwt_pkg::ctrl_cmd_type  cmd
);

   ffwt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffwt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ffwt_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture  = 1'b1;
               cmd.idx_clr  = 1'b1;
               cmd.pend_clr = 1'b1;
               unique case (req_opcode)
                  ffwt_pkg::OP_INSERT: state_in = ffwt_pkg::S_INSERT;
                  ffwt_pkg::OP_REMOVE: state_in = ffwt_pkg::S_REMOVE;
                  default:             state_in = ffwt_pkg::S_LIST;
               endcase
            end
         end
         ffwt_pkg::S_INSERT: begin
            cmd.out_src  = ffwt_pkg::SRC_KEY;
            cmd.out_last = 1'b1;
            priority if (stat.full) begin
               cmd.out_status = ffwt_pkg::STS_FULL;
               if (stat.out_ok) begin
                  cmd.out_load = 1'b1;
                  state_in     = ffwt_pkg::S_IDLE;
               end
            end else if (stat.at_end) begin
               cmd.out_status = ffwt_pkg::STS_INSERTED;
               cmd.wr_sel     = ffwt_pkg::WR_APPEND;
               if (stat.out_ok) begin
                  cmd.out_load = 1'b1;
                  cmd.ram_we   = 1'b1;
                  cmd.cnt_inc  = 1'b1;
                  state_in     = ffwt_pkg::S_IDLE;
               end
            end else if (stat.name_eq) begin
               cmd.out_status = ffwt_pkg::STS_DUPLICATE;
               if (stat.out_ok) begin
                  cmd.out_load = 1'b1;
                  state_in     = ffwt_pkg::S_IDLE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ffwt_pkg::S_REMOVE: begin
            cmd.out_last = 1'b1;
            priority if (stat.at_end) begin
               cmd.out_src    = ffwt_pkg::SRC_NONE;
               cmd.out_status = ffwt_pkg::STS_NOT_FOUND;
               if (stat.out_ok) begin
                  cmd.out_load = 1'b1;
                  state_in     = ffwt_pkg::S_IDLE;
               end
            end else if (stat.size_fit) begin
               cmd.out_src    = ffwt_pkg::SRC_ENTRY;
               cmd.out_status = ffwt_pkg::STS_REMOVED;
               if (stat.out_ok) begin
                  cmd.out_load = 1'b1;
                  cmd.idx_inc  = 1'b1;
                  state_in     = ffwt_pkg::S_SHIFT;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ffwt_pkg::S_SHIFT: begin
            cmd.wr_sel = ffwt_pkg::WR_SHIFT;
            if (stat.at_end) begin
               cmd.cnt_dec = 1'b1;
               state_in    = ffwt_pkg::S_IDLE;
            end else begin
               cmd.ram_we  = 1'b1;
               cmd.idx_inc = 1'b1;
            end
         end
         ffwt_pkg::S_LIST: begin
            // one matching entry is held back until it is known whether it is last
            priority if (stat.at_end) begin
               cmd.out_last = 1'b1;
               if (stat.pend_valid) begin
                  cmd.out_src    = ffwt_pkg::SRC_PEND;
                  cmd.out_status = ffwt_pkg::STS_ENTRY;
               end else begin
                  cmd.out_src    = ffwt_pkg::SRC_NONE;
                  cmd.out_status = ffwt_pkg::STS_NONE;
               end
               if (stat.out_ok) begin
                  cmd.out_load = 1'b1;
                  cmd.pend_clr = 1'b1;
                  state_in     = ffwt_pkg::S_IDLE;
               end
            end else if (stat.list_all || stat.size_fit) begin
               cmd.out_src    = ffwt_pkg::SRC_PEND;
               cmd.out_status = ffwt_pkg::STS_ENTRY;
               if (!stat.pend_valid) begin
                  cmd.pend_load = 1'b1;
                  cmd.idx_inc   = 1'b1;
               end else if (stat.out_ok) begin
                  cmd.out_load  = 1'b1;
                  cmd.pend_load = 1'b1;
                  cmd.idx_inc   = 1'b1;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         default: begin
            state_in = ffwt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

>>> tb/first_fit_waitlist_table_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the first-fit waitlist table: queue-fed driver, predictor, checker.

module first_fit_waitlist_table_top_tb;
   import ffwt_pkg::*;

   localparam int POOL_SIZE    = 24;
   localparam int ROUNDS       = 12;
   localparam int ROUND_LEN    = 32;
   localparam int TAIL_CYCLES  = 4 * (TABLE_DEPTH + 2);
   localparam int IDLE_LIMIT   = 4000;
   localparam int PRESSURE_AT  = 200;
   localparam int PRESSURE_LEN = 400;
   localparam int REPORT_MAX   = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // stimulus and expected results
   req_type      pending_reqs[$];
   rsp_type      waitlist_rsps[$];
   rsp_type      want;
   logic [151:0] pool_keys[POOL_SIZE];
   int           pool_lens[POOL_SIZE];

   // predictor copy of the table
   logic [KEY_W-1:0]  wl_names[TABLE_DEPTH];
   logic [SIZE_W-1:0] wl_sizes[TABLE_DEPTH];
   int                wl_count = 0;

   logic req_taken     = 1'b0;
   int   reqs_accepted = 0;
   int   total_items   = 0;
   int   fault_count   = 0;
   int   idle_cycles   = 0;
   int   hold_left     = 0;
   bit   hold_done     = 1'b0;
   int   send_idle_pct;
   int   recv_idle_pct;

   first_fit_waitlist_table_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // name is cut at its first zero byte and after NAME_BYTES-1 bytes
   function automatic logic [KEY_W-1:0] trim_name(logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] key;
      int               keep;
      key  = '0;
      keep = 0;
      while (keep < KEY_BYTES && keep < NAME_BYTES - 1 && raw[8*keep +: 8] != 8'h00) begin
         key[8*keep +: 8] = raw[8*keep +: 8];
         keep++;
      end
      return key;
   endfunction

   function automatic rsp_type make_rsp(status_type st, logic [KEY_W-1:0] nm,
                                        logic [SIZE_W-1:0] sz, logic fin);
      rsp_type r;
      r.status        = st;
      r.out_name_low  = nm[63:0];
      r.out_name_mid  = nm[127:64];
      r.out_name_high = nm[151:128];
      r.out_size      = sz;
      r.last          = fin;
      return r;
   endfunction

   task automatic predict_waitlist(input req_type r);
      logic [KEY_W-1:0] key;
      int               hit;
      int               shown;
      key   = trim_name({r.name_word_high, r.name_word_mid, r.name_word_low});
      hit   = -1;
      shown = 0;
      case (opcode_type'(r.opcode))
         OP_INSERT: begin
            if (wl_count >= TABLE_DEPTH) begin
               waitlist_rsps.push_back(make_rsp(STS_FULL, key, r.party_size, 1'b1));
            end else begin
               for (int i = 0; i < wl_count; i++) begin
                  if (hit < 0 && wl_names[i] == key) hit = i;
               end
               if (hit >= 0) begin
                  waitlist_rsps.push_back(make_rsp(STS_DUPLICATE, key, r.party_size, 1'b1));
               end else begin
                  wl_names[wl_count] = key;
                  wl_sizes[wl_count] = r.party_size;
                  wl_count++;
                  waitlist_rsps.push_back(make_rsp(STS_INSERTED, key, r.party_size, 1'b1));
               end
            end
         end
         OP_REMOVE: begin
            for (int i = 0; i < wl_count; i++) begin
               if (hit < 0 && wl_sizes[i] <= r.party_size) hit = i;
            end
            if (hit >= 0) begin
               waitlist_rsps.push_back(make_rsp(STS_REMOVED, wl_names[hit], wl_sizes[hit], 1'b1));
               for (int j = hit; j + 1 < wl_count; j++) begin
                  wl_names[j] = wl_names[j + 1];
                  wl_sizes[j] = wl_sizes[j + 1];
               end
               wl_count--;
            end else begin
               waitlist_rsps.push_back(make_rsp(STS_NOT_FOUND, '0, '0, 1'b1));
            end
         end
         default: begin
            for (int i = 0; i < wl_count; i++) begin
               if (opcode_type'(r.opcode) == OP_LIST || wl_sizes[i] <= r.party_size) begin
                  waitlist_rsps.push_back(make_rsp(STS_ENTRY, wl_names[i], wl_sizes[i], 1'b0));
                  shown++;
               end
            end
            if (shown == 0) begin
               waitlist_rsps.push_back(make_rsp(STS_NONE, '0, '0, 1'b1));
            end else begin
               waitlist_rsps[waitlist_rsps.size() - 1].last = 1'b1;
            end
         end
      endcase
   endtask

   function automatic req_type make_req(opcode_type op, logic [KEY_W-1:0] raw,
                                        logic [SIZE_W-1:0] sz);
      req_type r;
      r.opcode         = op;
      r.name_word_low  = raw[63:0];
      r.name_word_mid  = raw[127:64];
      r.name_word_high = raw[151:128];
      r.party_size     = sz;
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] random_raw();
      logic [159:0] wide;
      wide = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return wide[KEY_W-1:0];
   endfunction

   // pool name with random bytes after its terminator
   function automatic logic [KEY_W-1:0] pool_raw(int idx);
      logic [KEY_W-1:0] raw;
      raw = random_raw();
      for (int b = 0; b < KEY_BYTES; b++) begin
         if (b < pool_lens[idx]) begin
            raw[8*b +: 8] = pool_keys[idx][8*b +: 8];
         end else if (b == pool_lens[idx]) begin
            raw[8*b +: 8] = 8'h00;
         end
      end
      return raw;
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return SIZE_W'($urandom_range(15));
      if (roll < 55) return 16'h0000;
      if (roll < 60) return 16'hFFFF;
      return SIZE_W'($urandom_range(16'hFFFF));
   endfunction

   always_comb begin
      if (reqs_accepted < total_items / 3) begin
         send_idle_pct = 13;
         recv_idle_pct = 62;
      end else if (reqs_accepted < 2 * total_items / 3) begin
         send_idle_pct = 62;
         recv_idle_pct = 13;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off to back the table up
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && reqs_accepted >= PRESSURE_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= PRESSURE_LEN;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (waitlist_rsps.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_MAX) begin
                  $display("unexpected transaction: status %0d name %h size %0d last %b",
                           rsp_data.status,
                           {rsp_data.out_name_high, rsp_data.out_name_mid, rsp_data.out_name_low},
                           rsp_data.out_size, rsp_data.last);
               end
            end else begin
               want = waitlist_rsps.pop_front();
               if (rsp_data.status !== want.status
                   || rsp_data.out_name_low !== want.out_name_low
                   || rsp_data.out_name_mid !== want.out_name_mid
                   || rsp_data.out_name_high !== want.out_name_high
                   || rsp_data.out_size !== want.out_size
                   || rsp_data.last !== want.last) begin
                  fault_count++;
                  if (fault_count <= REPORT_MAX) begin
                     $display("mismatch: expected status %0d name %h size %0d last %b",
                              want.status,
                              {want.out_name_high, want.out_name_mid, want.out_name_low},
                              want.out_size, want.last);
                     $display("          actual   status %0d name %h size %0d last %b",
                              rsp_data.status,
                              {rsp_data.out_name_high, rsp_data.out_name_mid,
                               rsp_data.out_name_low},
                              rsp_data.out_size, rsp_data.last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_waitlist(req_data);
            reqs_accepted++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles < IDLE_LIMIT) begin
            idle_cycles <= idle_cycles + 1;
         end else begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      logic [KEY_W-1:0]  raw;
      logic [SIZE_W-1:0] sz;
      opcode_type        op;
      int                roll;
      bit                fill_mode;

      for (int p = 0; p < POOL_SIZE; p++) begin
         pool_lens[p] = (p == 0) ? KEY_BYTES : (p == 1) ? 1 : $urandom_range(KEY_BYTES);
         pool_keys[p] = '0;
         for (int b = 0; b < pool_lens[p]; b++) begin
            pool_keys[p][8*b +: 8] = 8'($urandom_range(1, 255));
         end
      end

      // directed: empty table, name extremes, cut names, duplicates, first fit
      pending_reqs.push_back(make_req(OP_LIST, random_raw(), 16'h0000));
      pending_reqs.push_back(make_req(OP_SHOW, random_raw(), 16'hFFFF));
      pending_reqs.push_back(make_req(OP_REMOVE, random_raw(), 16'hFFFF));
      pending_reqs.push_back(make_req(OP_INSERT, '0, 16'h0000));
      pending_reqs.push_back(make_req(OP_INSERT, '1, 16'hFFFF));
      raw = '1;
      raw[23:0] = 24'h006261;
      pending_reqs.push_back(make_req(OP_INSERT, raw, 16'd7));
      raw = random_raw();
      raw[23:0] = 24'h006261;
      pending_reqs.push_back(make_req(OP_INSERT, raw, 16'd9));
      raw = random_raw();
      raw[7:0] = 8'h00;
      pending_reqs.push_back(make_req(OP_INSERT, raw, 16'd3));
      pending_reqs.push_back(make_req(OP_LIST, '0, 16'h0000));
      pending_reqs.push_back(make_req(OP_SHOW, '1, 16'h0000));
      pending_reqs.push_back(make_req(OP_SHOW, '0, 16'd8));
      pending_reqs.push_back(make_req(OP_REMOVE, '0, 16'd6));
      pending_reqs.push_back(make_req(OP_REMOVE, '0, 16'd6));
      pending_reqs.push_back(make_req(OP_REMOVE, '1, 16'hFFFE));
      pending_reqs.push_back(make_req(OP_SHOW, '0, 16'hFFFE));
      pending_reqs.push_back(make_req(OP_LIST, '1, 16'hFFFF));
      pending_reqs.push_back(make_req(OP_REMOVE, '0, 16'hFFFF));
      pending_reqs.push_back(make_req(OP_LIST, '0, 16'h0000));

      // random: alternating fill-heavy and drain-heavy rounds, with some noise
      for (int rnd = 0; rnd < ROUNDS; rnd++) begin
         fill_mode = (rnd % 2 == 0);
         for (int k = 0; k < ROUND_LEN; k++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
               op  = opcode_type'($urandom_range(3));
               raw = random_raw();
               sz  = SIZE_W'($urandom_range(16'hFFFF));
            end else begin
               roll = $urandom_range(99);
               if (fill_mode) begin
                  op = (roll < 65) ? OP_INSERT : (roll < 80) ? OP_REMOVE :
                       (roll < 90) ? OP_LIST : OP_SHOW;
               end else begin
                  op = (roll < 20) ? OP_INSERT : (roll < 70) ? OP_REMOVE :
                       (roll < 82) ? OP_LIST : OP_SHOW;
               end
               raw = pool_raw($urandom_range(POOL_SIZE - 1));
               sz  = pick_size();
            end
            pending_reqs.push_back(make_req(op, raw, sz));
         end
      end
      total_items = pending_reqs.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_valid) @(posedge clock);
      while (waitlist_rsps.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/ffwt_pkg.sv
rtl/ffwt_ram.sv
rtl/ffwt_datapath.sv
rtl/ffwt_ctrl.sv
rtl/first_fit_waitlist_table_top.sv
tb/first_fit_waitlist_table_top_tb.sv
